/* rtl/ent_pkg.sv */
`default_nettype none

package ent_pkg;

  // Drive modes
  localparam logic [1:0] MODE_STOP = 2'd0;
  localparam logic [1:0] MODE_FWD  = 2'd1;
  localparam logic [1:0] MODE_REV  = 2'd2;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 4;
  localparam logic [CfgIdxW-1:0] CFG_LOCO_ID    = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_NOTCH_STEP = 4'd1;

  localparam int unsigned CfgDataW = 14;

  // Reset values
  localparam logic [13:0] LOCO_ID_RST    = 14'd0;
  localparam logic [7:0]  NOTCH_STEP_RST = 8'd10;
  localparam logic [2:0]  PHASE_RST      = 3'd0;
  localparam logic [2:0]  PINS_NONE      = 3'd4;

  localparam logic [6:0] SPEED_MAX   = 7'd126;
  localparam logic [6:0] SPEED_ESTOP = 7'd1;

  // Decoder action codes
  localparam logic       ACT_POLL   = 1'b0;
  localparam logic       ACT_ATTACH = 1'b1;

  typedef struct packed {
    logic       action;
    logic       button_level;
    logic       dt_level;
    logic       clk_level;
    logic [6:0] speed_now;
    logic       forward_now;
  } ent_in_t;

  typedef struct packed {
    logic [6:0] new_speed;
    logic       forward;
  } ent_out_t;

  typedef struct packed {
    logic [2:0] phase;
    logic [2:0] last_pins;
    logic [1:0] mode;
  } ent_state_t;

  typedef struct packed {
    logic [13:0] loco_id;
    logic [7:0]  notch_step;
  } ent_cfg_t;

  // Detent table entry: {ccw, cw, next phase}
  typedef struct packed {
    logic       ccw;
    logic       cw;
    logic [2:0] phase;
  } ent_entry_t;

  function automatic ent_entry_t step_entry(input logic [2:0] phase, input logic [1:0] pins);
    ent_entry_t e;
    e = '0;
    unique case (phase)
      3'd1: begin
        e.phase = (pins == 2'd3) ? 3'd2 : 3'd1;
        e.cw    = (pins == 2'd3);
      end
      3'd2: e.phase = (pins == 2'd2) ? 3'd0 : 3'd2;
      3'd3: begin
        e.phase = (pins == 2'd3) ? 3'd4 : 3'd3;
        e.ccw   = (pins == 2'd3);
      end
      3'd4: e.phase = (pins == 2'd1) ? 3'd0 : 3'd4;
      default: begin
        // phase zero, and any out-of-range phase decodes as zero
        unique case (pins)
          2'd1:    e.phase = 3'd1;
          2'd2:    e.phase = 3'd3;
          default: e.phase = 3'd0;
        endcase
      end
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

/* rtl/ent_step.sv */
`default_nettype none

module ent_step (
  input  var ent_pkg::ent_in_t    item_i,
  input  var ent_pkg::ent_state_t state_i,
  input  var ent_pkg::ent_cfg_t   cfg_i,
  output ent_pkg::ent_state_t     state_o,
  output logic                    has_result_o,
  output ent_pkg::ent_out_t       result_o
);

  logic [1:0]         pins;
  ent_pkg::ent_entry_t entry;
  logic [1:0]         mode_eff;
  logic               up;
  logic [6:0]         sp0;
  logic [8:0]         sum;
  logic [6:0]         up_speed;
  logic [6:0]         dn_speed;
  logic [6:0]         nsp;

  always_comb begin
    pins  = {item_i.dt_level, item_i.clk_level};
    entry = ent_pkg::step_entry(state_i.phase, pins);

    // direction picked by the first detent after a stop
    mode_eff = state_i.mode;
    if (state_i.mode == ent_pkg::MODE_STOP) begin
      mode_eff = entry.cw ? ent_pkg::MODE_FWD : ent_pkg::MODE_REV;
    end
    up = (mode_eff == ent_pkg::MODE_REV) ? ~entry.cw : entry.cw;

    // fold emergency stop to zero, then step with saturation
    sp0 = (item_i.speed_now == ent_pkg::SPEED_ESTOP) ? 7'd0 : item_i.speed_now;
    sum = {2'b00, sp0} + {1'b0, cfg_i.notch_step};
    up_speed = (sum > {2'b00, ent_pkg::SPEED_MAX}) ? ent_pkg::SPEED_MAX : sum[6:0];
    dn_speed = (cfg_i.notch_step > {1'b0, sp0}) ? 7'd0 : (sp0 - cfg_i.notch_step[6:0]);
    nsp = up ? up_speed : dn_speed;
    if (nsp == ent_pkg::SPEED_ESTOP) begin
      nsp = 7'd0;
    end
  end

  always_comb begin
    state_o      = state_i;
    has_result_o = 1'b0;
    result_o     = '0;
    if (item_i.action == ent_pkg::ACT_ATTACH) begin
      // attach: reset phase, inherit direction of a moving loco
      state_o.phase = ent_pkg::PHASE_RST;
      state_o.mode  = ent_pkg::MODE_STOP;
      if (cfg_i.loco_id != '0 && item_i.speed_now > 7'd1) begin
        state_o.mode = item_i.forward_now ? ent_pkg::MODE_FWD : ent_pkg::MODE_REV;
      end
    end else if (cfg_i.loco_id != '0) begin
      if (item_i.button_level) begin
        // emergency stop, once until the encoder moves
        if (state_i.mode != ent_pkg::MODE_STOP) begin
          state_o.mode       = ent_pkg::MODE_STOP;
          has_result_o       = 1'b1;
          result_o.new_speed = ent_pkg::SPEED_ESTOP;
          result_o.forward   = item_i.forward_now;
        end
      end else if ({1'b0, pins} != state_i.last_pins) begin
        state_o.last_pins = {1'b0, pins};
        state_o.phase     = entry.phase;
        if (entry.cw || entry.ccw) begin
          state_o.mode       = mode_eff;
          has_result_o       = (nsp != sp0);
          result_o.new_speed = nsp;
          result_o.forward   = (mode_eff == ent_pkg::MODE_FWD);
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/encoder_notch_throttle_core.sv */
`default_nettype none

// Rotary encoder throttle for one loco.
// Input channel (in_valid_i / in_ready_o / in_data_i): one beat per poll of
// the button and encoder pins, or one attach beat when a loco is taken over.
// Output channel (out_valid_o / out_ready_i / out_data_o): a beat only when
// the commanded speed or an emergency stop must be sent.
// Config channel (cfg_valid_i / cfg_index_i / cfg_data_i): always ready;
// write loco_id and notch_step only while no beat is in flight.
// An input beat is registered, decoded against the phase, pin and mode
// registers, and its result is written to the output register when the
// beat advances. One beat per cycle while no held result stalls it, set
// by the single decode step between input and output registers.
// Reset clears phase to zero, pins to no valid pair, mode to stopped,
// loco_id to zero and notch_step to ten. While the receiver stalls a held
// result, a second beat that would give a result waits in the input
// register and in_ready_o drops.
module encoder_notch_throttle_core (
  input  var logic                         clk_i,
  input  var logic                         rst_ni,
  input  var logic                         in_valid_i,
  output logic                             in_ready_o,
  input  var ent_pkg::ent_in_t             in_data_i,
  output logic                             out_valid_o,
  input  var logic                         out_ready_i,
  output ent_pkg::ent_out_t                out_data_o,
  input  var logic                         cfg_valid_i,
  output logic                             cfg_ready_o,
  input  var logic [ent_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  var logic [ent_pkg::CfgDataW-1:0] cfg_data_i
);

  logic                in_vld_q;
  ent_pkg::ent_in_t    in_q;
  ent_pkg::ent_state_t state_q, state_d;
  ent_pkg::ent_cfg_t   cfg_q;
  logic                out_vld_q;
  ent_pkg::ent_out_t   out_q;
  logic                has_result;
  ent_pkg::ent_out_t   result;
  logic                advance;

  ent_step u_step (
    .item_i       (in_q),
    .state_i      (state_q),
    .cfg_i        (cfg_q),
    .state_o      (state_d),
    .has_result_o (has_result),
    .result_o     (result)
  );

  // advance when the result slot is free or nothing is produced
  assign advance     = in_vld_q && (!out_vld_q || out_ready_i || !has_result);
  assign in_ready_o  = !in_vld_q || advance;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase     <= ent_pkg::PHASE_RST;
      state_q.last_pins <= ent_pkg::PINS_NONE;
      state_q.mode      <= ent_pkg::MODE_STOP;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.loco_id    <= ent_pkg::LOCO_ID_RST;
      cfg_q.notch_step <= ent_pkg::NOTCH_STEP_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ent_pkg::CFG_LOCO_ID:    cfg_q.loco_id    <= cfg_data_i;
        ent_pkg::CFG_NOTCH_STEP: cfg_q.notch_step <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && has_result) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && has_result) begin
      out_q <= result;
    end
  end

  // checks
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase <= 3'd4) else $error("decoder phase out of range");

  a_pins_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.last_pins == ent_pkg::PINS_NONE || !state_q.last_pins[2])
    else $error("stored pin pair malformed");

  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> out_q.new_speed <= ent_pkg::SPEED_MAX)
    else $error("result speed above maximum");

  a_estop_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && has_result && result.new_speed == ent_pkg::SPEED_ESTOP)
    |=> state_q.mode == ent_pkg::MODE_STOP)
    else $error("emergency stop did not stop mode");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ready_i) |-> !(advance && has_result))
    else $error("held result overwritten");

endmodule

`default_nettype wire

/* sim/encoder_notch_throttle_core_tb.sv */
`timescale 1ns / 100ps

module encoder_notch_throttle_core_tb;
  import ent_pkg::*;

  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldCycles  = 300;
  // Index that maps to no register; a write there must change nothing
  localparam logic [CfgIdxW-1:0] CFG_SPARE = 4'd15;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  ent_in_t             in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  ent_out_t            out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // Mirror of the throttle state and registers
  logic [2:0]  phase_q;
  logic [2:0]  pins_q;
  logic [1:0]  mode_q;
  logic [13:0] loco_q;
  logic [7:0]  notch_q;

  ent_out_t    speed_cmds_q[$];
  int unsigned mismatch_count;

  // Loco as the stimulus sees it, fed back from the commanded speed
  logic [6:0]  loco_speed;
  logic        loco_fwd;

  int unsigned burst_left;
  int unsigned hold_issued;

  encoder_notch_throttle_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Quadrature step: returns {ccw, cw, next phase}
  function automatic logic [4:0] detent_entry(input logic [2:0] ph, input logic [1:0] pins);
    logic [4:0] e;
    case (ph)
      3'd1: e = (pins == 2'b11) ? 5'b01010 : 5'b00001;
      3'd2: e = (pins == 2'b10) ? 5'b00000 : 5'b00010;
      3'd3: e = (pins == 2'b11) ? 5'b10100 : 5'b00011;
      3'd4: e = (pins == 2'b01) ? 5'b00000 : 5'b00100;
      default: begin
        // phase zero; anything out of range decodes the same way
        if (pins == 2'b01) e = 5'b00001;
        else if (pins == 2'b10) e = 5'b00011;
        else e = 5'b00000;
      end
    endcase
    return e;
  endfunction

  // Advance the mirror by one accepted beat and queue any speed command
  function automatic void predict_throttle(input ent_in_t item);
    logic [1:0] pins;
    logic [4:0] e;
    logic       up;
    int         old_spd;
    int         new_spd;
    ent_out_t   cmd;

    if (item.action == ACT_ATTACH) begin
      phase_q = PHASE_RST;
      mode_q  = MODE_STOP;
      if (loco_q != '0 && item.speed_now > 7'd1) mode_q = item.forward_now ? MODE_FWD : MODE_REV;
      return;
    end
    if (loco_q == '0) return;

    if (item.button_level) begin
      if (mode_q == MODE_STOP) return;
      mode_q = MODE_STOP;
      cmd = '{new_speed: SPEED_ESTOP, forward: item.forward_now};
      speed_cmds_q.push_back(cmd);
      loco_speed = cmd.new_speed;
      loco_fwd   = cmd.forward;
      return;
    end

    pins = {item.dt_level, item.clk_level};
    if ({1'b0, pins} == pins_q) return;
    pins_q  = {1'b0, pins};
    e       = detent_entry(phase_q, pins);
    phase_q = e[2:0];
    if (e[4:3] == 2'b00) return;

    up = e[3];
    if (mode_q == MODE_STOP) mode_q = up ? MODE_FWD : MODE_REV;
    if (mode_q == MODE_REV) up = !up;

    old_spd = int'(item.speed_now);
    if (old_spd == 1) old_spd = 0;
    if (up) begin
      new_spd = old_spd + int'(notch_q);
      if (new_spd > int'(SPEED_MAX)) new_spd = int'(SPEED_MAX);
    end else begin
      new_spd = old_spd - int'(notch_q);
      if (new_spd < 0) new_spd = 0;
    end
    if (new_spd == 1) new_spd = 0;
    if (new_spd == old_spd) return;

    cmd = '{new_speed: 7'(new_spd), forward: (mode_q == MODE_FWD)};
    speed_cmds_q.push_back(cmd);
    loco_speed = cmd.new_speed;
    loco_fwd   = cmd.forward;
  endfunction

  function automatic ent_in_t mk_item(input logic act, input logic btn, input logic dt,
                                      input logic clk, input logic [6:0] spd, input logic fwd);
    ent_in_t item;
    item = '{action: act, button_level: btn, dt_level: dt, clk_level: clk,
             speed_now: spd, forward_now: fwd};
    return item;
  endfunction

  function automatic logic [6:0] pick_speed();
    if ($urandom_range(0, 4) == 0) return 7'($urandom_range(0, 127));
    return loco_speed;
  endfunction

  function automatic logic pick_fwd();
    if ($urandom_range(0, 5) == 0) return 1'($urandom_range(0, 1));
    return loco_fwd;
  endfunction

  // End a burst now and then with a random gap
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
  endtask

  // Offer one beat, hold it until accepted, then predict
  task automatic send_item(input ent_in_t item);
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    predict_throttle(item);
    pace_sender();
  endtask

  task automatic poll_pins(input logic btn, input logic dt, input logic clk,
                           input logic [6:0] spd, input logic fwd);
    send_item(mk_item(1'(ACT_POLL), btn, dt, clk, spd, fwd));
  endtask

  // One detent from rest: 00 then the three quadrature steps; fewer polls break it off
  task automatic turn_detent(input logic cw, input logic [6:0] spd, input logic fwd,
                             input int unsigned polls);
    logic [1:0] seq [4];
    if (cw) begin
      seq[0] = 2'b00; seq[1] = 2'b01; seq[2] = 2'b11; seq[3] = 2'b10;
    end else begin
      seq[0] = 2'b00; seq[1] = 2'b10; seq[2] = 2'b11; seq[3] = 2'b01;
    end
    for (int i = 0; i < polls; i++) poll_pins(1'b0, seq[i][1], seq[i][0], spd, fwd);
  endtask

  // Drop valid, wait for every command, then let in-flight beats settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (speed_cmds_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_LOCO_ID:    loco_q  = data;
      CFG_NOTCH_STEP: notch_q = data[7:0];
      default: ;
    endcase
  endtask

  // Mostly whole detents with random speed; the rest buttons, attaches and noise
  task automatic run_random(input int unsigned n);
    int unsigned sent;
    int unsigned r;
    ent_in_t     item;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      if (r < 62) begin
        turn_detent(1'($urandom_range(0, 1)), pick_speed(), pick_fwd(),
                    ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 4);
        sent += 4;
      end else if (r < 72) begin
        poll_pins(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  pick_speed(), pick_fwd());
        sent++;
      end else if (r < 78) begin
        send_item(mk_item(ACT_ATTACH, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), pick_speed(), pick_fwd()));
        sent++;
      end else begin
        item = ent_in_t'($urandom_range(0, 4095));
        send_item(item);
        sent++;
      end
    end
  endtask

  // No loco selected: polls do nothing
  task automatic test_idle_throttle();
    turn_detent(1'b1, 7'd0, 1'b1, 4);
    poll_pins(1'b1, 1'b0, 1'b0, 7'd20, 1'b1);
  endtask

  task automatic test_detent_turns();
    write_reg(CFG_LOCO_ID, 14'd3);
    // first turn from stop picks forward; estop speed counts as zero
    turn_detent(1'b1, 7'd1, 1'b0, 4);
    // speed input 127 taken as it stands
    turn_detent(1'b0, 7'd127, 1'b1, 4);
    // same pins again: ignored
    poll_pins(1'b0, 1'b0, 1'b1, 7'd117, 1'b1);
  endtask

  task automatic test_emergency_stop();
    poll_pins(1'b1, 1'b1, 1'b1, 7'd117, 1'b1);
    // already stopped: no second estop
    poll_pins(1'b1, 1'b0, 1'b0, 7'd1, 1'b1);
    // counter-clockwise after a stop selects reverse and speeds up
    turn_detent(1'b0, 7'd1, 1'b1, 4);
  endtask

  task automatic test_attach();
    send_item(mk_item(ACT_ATTACH, 1'b0, 1'b0, 1'b1, 7'd50, 1'b1));
    // saturated at top: no command
    turn_detent(1'b1, SPEED_MAX, 1'b1, 4);
  endtask

  // Receiver holds off long while detents keep coming, so the input backs up
  task automatic test_output_stall();
    write_reg(CFG_NOTCH_STEP, 14'd10);
    write_reg(CFG_LOCO_ID, 14'd42);
    loco_speed = 7'd60;
    hold_issued++;
    for (int i = 0; i < 50; i++) turn_detent(1'(i % 2), loco_speed, loco_fwd, 4);
  endtask

  task automatic test_random_settings();
    write_reg(CFG_LOCO_ID, 14'd10239);
    run_random(200);
    write_reg(CFG_NOTCH_STEP, {6'($urandom), 8'd255});
    write_reg(CFG_LOCO_ID, 14'd1);
    run_random(150);
    write_reg(CFG_NOTCH_STEP, 14'd1);
    write_reg(CFG_LOCO_ID, 14'd77);
    run_random(200);
    write_reg(CFG_NOTCH_STEP, 14'd0);
    write_reg(CFG_LOCO_ID, 14'd5000);
    run_random(100);
    write_reg(CFG_LOCO_ID, 14'd0);
    write_reg(CFG_NOTCH_STEP, 14'd37);
    run_random(60);
    write_reg(CFG_SPARE, 14'($urandom));
    write_reg(CFG_LOCO_ID, 14'($urandom_range(1, 10239)));
    write_reg(CFG_NOTCH_STEP, 14'($urandom_range(0, 16383)));
    run_random(200);
    write_reg(CFG_NOTCH_STEP, 14'($urandom_range(2, 40)));
    run_random(100);
  endtask

  // Stall pattern of its own, plus a long hold-off on request
  initial begin : rx_stall
    int unsigned cyc;
    int unsigned style;
    int unsigned hold_left;
    int unsigned hold_seen;
    out_ready_i = 1'b0;
    cyc         = 0;
    style       = 0;
    hold_left   = 0;
    hold_seen   = 0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc % 64 == 0) style = $urandom_range(0, 3);
      if (hold_issued != hold_seen) begin
        hold_seen = hold_issued;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (style)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= ((cyc % 5) < 3);
        endcase
      end
    end
  end

  // Compare each command beat with the oldest prediction
  always @(posedge clk_i) begin : chk_cmd
    ent_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (speed_cmds_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual new_speed %0d forward %0b",
                 $time, out_data_o.new_speed, out_data_o.forward);
        mismatch_count++;
      end else begin
        want = speed_cmds_q.pop_front();
        if (out_data_o.new_speed !== want.new_speed) begin
          $display("%0t: new_speed expected %0d actual %0d",
                   $time, want.new_speed, out_data_o.new_speed);
          mismatch_count++;
        end
        if (out_data_o.forward !== want.forward) begin
          $display("%0t: forward expected %0b actual %0b",
                   $time, want.forward, out_data_o.forward);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("encoder_notch_throttle_core verification failed");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_LOCO_ID;
    cfg_data_i     = '0;
    phase_q        = PHASE_RST;
    pins_q         = PINS_NONE;
    mode_q         = MODE_STOP;
    loco_q         = LOCO_ID_RST;
    notch_q        = NOTCH_STEP_RST;
    loco_speed     = '0;
    loco_fwd       = 1'b1;
    mismatch_count = 0;
    burst_left     = 1;
    hold_issued    = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_throttle();
    test_detent_turns();
    test_emergency_stop();
    test_attach();
    test_output_stall();
    test_random_settings();

    wait_drained();
    if (mismatch_count == 0) begin
      $display("encoder_notch_throttle_core verification clean");
    end else begin
      $display("encoder_notch_throttle_core verification failed");
    end
    $finish;
  end

endmodule
